[rtl/ffa_pkg.sv]
package ffa_pkg;

    localparam int WORD_W    = 32;
    localparam int SIZE_BITS = 30;
    localparam int USED_BIT  = 31;
    localparam int ADDR_W    = 12;
    localparam int BYTES_W   = 15;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    // Rounded-up byte count: 15-bit request plus up to WORD_BYTES - 1 bytes of rounding
    localparam int NEED_W    = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_RESIZE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NO_MEM      = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_ZERO_SIZE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_HEAD,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_MWORD,
        WR_MERGE,
        WR_SHRINK,
        WR_GRANT,
        WR_SAVED
    } wr_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_ADDR,
        RES_GRANT
    } res_sel_t;

    typedef enum logic [1:0] {
        MS_NONE,
        MS_FREE,
        MS_TAIL,
        MS_GRANT
    } mrg_src_t;

    typedef struct packed {
        logic     latch;
        logic     div_start;
        logic     h_clear;
        logic     h_advance;
        logic     save_hdr;
        mrg_src_t mrg_src;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        logic     grant_take;
        logic     load_out;
        res_sel_t res_sel;
        status_t  status;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic bytes_zero;
        logic addr_bad;
        logic div_done;
        logic h_end;
        logic h_at_hdr;
        logic hd_used;
        logic g_fit;
        logic g_over;
        logic g_split;
        logic s_fit;
        logic s_split;
        logic n_end;
        logic out_busy;
    } dp_stat_t;

    function automatic logic [WORD_W-1:0] make_hdr(input logic used,
                                                   input logic [SIZE_BITS-1:0] sz);
        make_hdr = {used, 1'b0, sz};
    endfunction

endpackage

[rtl/ffa_req_if.sv]
interface ffa_req_if;
    logic                         valid;
    logic                         ready;
    logic [ffa_pkg::CMD_W-1:0]    command;
    logic [ffa_pkg::BYTES_W-1:0]  size_bytes;
    logic [ffa_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output command, output size_bytes, output address,
                    input ready);
    modport sink   (input valid, input command, input size_bytes, input address,
                    output ready);
endinterface

[rtl/ffa_rsp_if.sv]
interface ffa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffa_pkg::ADDR_W-1:0]    result_address;
    logic [ffa_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output result_address, output status, input ready);
    modport sink   (input valid, input result_address, input status, output ready);
endinterface

[rtl/ffa_div.sv]
// Ceiling divide of the byte count by the word size through a reciprocal multiply.
module ffa_div #(
    parameter int WORD_BYTES = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ffa_pkg::BYTES_W-1:0]   bytes,
    output logic [ffa_pkg::NEED_W-1:0]    need,
    output logic                          done
);
    localparam int XW    = ffa_pkg::NEED_W;
    localparam int LW    = $clog2(WORD_BYTES);
    // Shift of XW + ceil(log2(WORD_BYTES)) keeps the quotient exact for any XW-bit dividend
    localparam int K     = XW + LW;
    localparam int PRW   = K + XW;
    localparam int RECIP = ((1 << K) + WORD_BYTES - 1) / WORD_BYTES;

    logic [XW-1:0]  x;
    logic [PRW-1:0] prod;
    logic [XW-1:0]  need_reg;
    logic           done_reg;

    assign x    = XW'(bytes) + XW'(WORD_BYTES - 1);
    assign prod = PRW'(x) * PRW'(RECIP);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            need_reg <= prod[PRW-1:K];
        end
    end

    // Flag the word count as valid the cycle after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    assign need = need_reg;
    assign done = done_reg;

endmodule

[rtl/ffa_dp.sv]
// Heap memory, walk pointer, merge/split arithmetic and the result register.
module ffa_dp #(
    parameter int HEAP_WORDS = 4096,
    parameter int WORD_BYTES = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ffa_pkg::CMD_W-1:0]      req_command,
    input  logic [ffa_pkg::BYTES_W-1:0]    req_size_bytes,
    input  logic [ffa_pkg::ADDR_W-1:0]     req_address,
    input  logic                           rsp_ready,
    output logic                           rsp_valid,
    output logic [ffa_pkg::ADDR_W-1:0]     rsp_address,
    output logic [ffa_pkg::STATUS_W-1:0]   rsp_status,
    input  ffa_pkg::dp_cmd_t               cmd,
    output ffa_pkg::dp_stat_t              stat
);
    localparam int AW  = $clog2(HEAP_WORDS);
    localparam int PW  = AW + 1;
    localparam int SW  = (PW > ffa_pkg::NEED_W) ? PW : ffa_pkg::NEED_W;
    localparam int WW  = ffa_pkg::WORD_W;
    localparam int ZW  = ffa_pkg::SIZE_BITS;
    localparam int AdW = ffa_pkg::ADDR_W;
    localparam int UB  = ffa_pkg::USED_BIT;
    localparam logic [WW-1:0] RESET_HDR = WW'(HEAP_WORDS - 1);

    logic [WW-1:0]               mem [HEAP_WORDS];

    ffa_pkg::cmd_t               cmd_reg;
    logic [ffa_pkg::BYTES_W-1:0] bytes_reg;
    logic [AdW-1:0]              addr_reg;
    logic [PW-1:0]               h_reg;
    logic [WW-1:0]               saved_reg;
    logic [PW-1:0]               m_reg;
    logic [WW-1:0]               mword_reg;
    logic [AdW-1:0]              gres_reg;
    logic [WW-1:0]               rdata_reg;
    logic                        rd_zero_reg;
    logic                        init_reg;
    logic                        out_valid_reg;
    logic [AdW-1:0]              out_addr_reg;
    ffa_pkg::status_t            out_status_reg;

    logic [ffa_pkg::NEED_W-1:0]  need;
    logic                        div_done;
    logic [WW-1:0]               hd;
    logic [SW-1:0]               hd_sz;
    logic [SW-1:0]               need_s;
    logic [SW-1:0]               h_end_s;
    logic [31:0]                 hdr32;
    logic [PW-1:0]               hdr_p;
    logic [SW-1:0]               g_diff;
    logic [SW-1:0]               s_sz;
    logic [SW-1:0]               s_diff;
    logic [SW-1:0]               m_sz;
    logic [SW-1:0]               n_s;
    logic [SW-1:0]               m_total;
    logic                        rd_en;
    logic [AW-1:0]               raddr;
    logic                        wr_en;
    logic [AW-1:0]               waddr;
    logic [WW-1:0]               wdata;
    logic [AdW-1:0]              res_mux;

    ffa_div #(
        .WORD_BYTES (WORD_BYTES)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .bytes (bytes_reg),
        .need  (need),
        .done  (div_done)
    );

    // Word 0 reads as the initial free block until it is first written.
    assign hd      = rd_zero_reg ? RESET_HDR : rdata_reg;
    assign hd_sz   = SW'(hd[AW-1:0]);
    assign need_s  = SW'(need);
    assign h_end_s = SW'(h_reg) + SW'(1) + hd_sz;
    assign hdr32   = 32'(addr_reg) - 32'd1;
    assign hdr_p   = PW'(hdr32);
    assign g_diff  = hd_sz - need_s;
    assign s_sz    = SW'(saved_reg[AW-1:0]);
    assign s_diff  = s_sz - need_s;
    assign m_sz    = SW'(mword_reg[AW-1:0]);
    assign n_s     = SW'(m_reg) + SW'(1) + m_sz;
    assign m_total = m_sz + SW'(1) + hd_sz;

    always_comb
    begin
        stat            = '0;
        stat.cmd        = cmd_reg;
        stat.bytes_zero = bytes_reg == '0;
        stat.addr_bad   = (addr_reg == '0) || (hdr32 >= 32'(HEAP_WORDS));
        stat.div_done   = div_done;
        stat.h_end      = h_reg >= PW'(HEAP_WORDS);
        stat.h_at_hdr   = h_reg == hdr_p;
        stat.hd_used    = hd[UB];
        stat.g_fit      = !hd[UB] && (hd_sz >= need_s);
        stat.g_over     = h_end_s > SW'(HEAP_WORDS);
        stat.g_split    = g_diff > SW'(1);
        stat.s_fit      = s_sz >= need_s;
        stat.s_split    = s_diff > SW'(1);
        stat.n_end      = n_s >= SW'(HEAP_WORDS);
        stat.out_busy   = out_valid_reg && !rsp_ready;
    end

    always_comb
    begin
        rd_en = 1'b0;
        raddr = '0;
        case (cmd.rd_sel)
            ffa_pkg::RD_HEAD:
            begin
                rd_en = 1'b1;
                raddr = h_reg[AW-1:0];
            end
            ffa_pkg::RD_NEXT:
            begin
                rd_en = 1'b1;
                raddr = n_s[AW-1:0];
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_en = 1'b1;
        waddr = '0;
        wdata = '0;
        case (cmd.wr_sel)
            ffa_pkg::WR_MWORD:
            begin
                waddr = m_reg[AW-1:0];
                wdata = mword_reg;
            end
            ffa_pkg::WR_MERGE:
            begin
                waddr = m_reg[AW-1:0];
                wdata = hd[UB] ? mword_reg
                               : ffa_pkg::make_hdr(mword_reg[UB], ZW'(m_total));
            end
            ffa_pkg::WR_SHRINK:
            begin
                waddr = hdr_p[AW-1:0];
                wdata = ffa_pkg::make_hdr(1'b1, ZW'(need_s));
            end
            ffa_pkg::WR_GRANT:
            begin
                waddr = h_reg[AW-1:0];
                wdata = ffa_pkg::make_hdr(1'b1, ZW'(stat.g_split ? need_s : hd_sz));
            end
            ffa_pkg::WR_SAVED:
            begin
                waddr = hdr_p[AW-1:0];
                wdata = saved_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= 1'b0;
            rd_zero_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && (waddr == '0))
            begin
                init_reg <= 1'b1;
            end
            if (rd_en)
            begin
                rd_zero_reg <= (raddr == '0) && !init_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        case (cmd.res_sel)
            ffa_pkg::RES_ADDR:  res_mux = addr_reg;
            ffa_pkg::RES_GRANT: res_mux = gres_reg;
            default:            res_mux = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg   <= ffa_pkg::cmd_t'(req_command);
            bytes_reg <= req_size_bytes;
            addr_reg  <= req_address;
        end
        if (cmd.h_clear)
        begin
            h_reg <= '0;
        end
        else if (cmd.h_advance)
        begin
            h_reg <= PW'(h_end_s);
        end
        if (cmd.save_hdr)
        begin
            saved_reg <= hd;
        end
        case (cmd.mrg_src)
            ffa_pkg::MS_FREE:
            begin
                m_reg     <= hdr_p;
                mword_reg <= ffa_pkg::make_hdr(1'b0, saved_reg[ZW-1:0]);
            end
            ffa_pkg::MS_TAIL:
            begin
                m_reg     <= PW'(SW'(hdr_p) + SW'(1) + need_s);
                mword_reg <= ffa_pkg::make_hdr(1'b0, ZW'(s_diff - SW'(1)));
            end
            ffa_pkg::MS_GRANT:
            begin
                m_reg     <= PW'(SW'(h_reg) + SW'(1) + need_s);
                mword_reg <= ffa_pkg::make_hdr(1'b0, ZW'(g_diff - SW'(1)));
            end
            default:
            begin
                m_reg <= m_reg;
            end
        endcase
        if (cmd.grant_take)
        begin
            gres_reg <= AdW'(h_reg + PW'(1));
        end
        if (cmd.load_out)
        begin
            out_addr_reg   <= res_mux;
            out_status_reg <= cmd.status;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign rsp_address = out_addr_reg;
    assign rsp_status  = out_status_reg;

endmodule

[rtl/ffa_ctrl.sv]
// Sequencer: address check walk, divide, merge, first-fit walk, response.
module ffa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output ffa_pkg::dp_cmd_t  cmd,
    input  ffa_pkg::dp_stat_t stat
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHK_RD,
        S_CHK_EV,
        S_FREE_SET,
        S_DIV,
        S_RESIZE,
        S_MRG_RD,
        S_MRG_EV,
        S_G_RD,
        S_G_EV,
        S_G_SPLIT,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        RET_FREE,
        RET_SHRINK,
        RET_GROW
    } mret_t;

    state_t             state_reg, state_next;
    mret_t              mret_reg, mret_next;
    ffa_pkg::status_t   rsp_status_reg, rsp_status_next;
    ffa_pkg::res_sel_t  rsp_res_reg, rsp_res_next;

    always_comb
    begin
        state_next      = state_reg;
        mret_next       = mret_reg;
        rsp_status_next = rsp_status_reg;
        rsp_res_next    = rsp_res_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    ffa_pkg::CMD_ALLOC:
                    begin
                        if (stat.bytes_zero)
                        begin
                            rsp_status_next = ffa_pkg::ST_ZERO_SIZE;
                            rsp_res_next    = ffa_pkg::RES_ZERO;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    ffa_pkg::CMD_FREE, ffa_pkg::CMD_RESIZE:
                    begin
                        if (stat.addr_bad)
                        begin
                            rsp_status_next = ffa_pkg::ST_DOUBLE_FREE;
                            rsp_res_next    = ffa_pkg::RES_ZERO;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            cmd.h_clear = 1'b1;
                            state_next  = S_CHK_RD;
                        end
                    end
                    default:
                    begin
                        rsp_status_next = ffa_pkg::ST_OK;
                        rsp_res_next    = ffa_pkg::RES_ZERO;
                        state_next      = S_RESP;
                    end
                endcase
            end
            S_CHK_RD:
            begin
                if (stat.h_end)
                begin
                    rsp_status_next = ffa_pkg::ST_DOUBLE_FREE;
                    rsp_res_next    = ffa_pkg::RES_ZERO;
                    state_next      = S_RESP;
                end
                else
                begin
                    cmd.rd_sel = ffa_pkg::RD_HEAD;
                    state_next = S_CHK_EV;
                end
            end
            S_CHK_EV:
            begin
                if (!stat.h_at_hdr)
                begin
                    cmd.h_advance = 1'b1;
                    state_next    = S_CHK_RD;
                end
                else if (!stat.hd_used)
                begin
                    rsp_status_next = ffa_pkg::ST_DOUBLE_FREE;
                    rsp_res_next    = ffa_pkg::RES_ZERO;
                    state_next      = S_RESP;
                end
                else
                begin
                    cmd.save_hdr = 1'b1;
                    if (stat.cmd == ffa_pkg::CMD_FREE)
                    begin
                        state_next = S_FREE_SET;
                    end
                    else if (stat.bytes_zero)
                    begin
                        rsp_status_next = ffa_pkg::ST_ZERO_SIZE;
                        rsp_res_next    = ffa_pkg::RES_ZERO;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_FREE_SET:
            begin
                cmd.mrg_src = ffa_pkg::MS_FREE;
                mret_next   = RET_FREE;
                state_next  = S_MRG_RD;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.cmd == ffa_pkg::CMD_ALLOC)
                    begin
                        cmd.h_clear = 1'b1;
                        state_next  = S_G_RD;
                    end
                    else
                    begin
                        state_next = S_RESIZE;
                    end
                end
            end
            S_RESIZE:
            begin
                if (!stat.s_fit)
                begin
                    cmd.mrg_src = ffa_pkg::MS_FREE;
                    mret_next   = RET_GROW;
                    state_next  = S_MRG_RD;
                end
                else if (stat.s_split)
                begin
                    cmd.wr_sel  = ffa_pkg::WR_SHRINK;
                    cmd.mrg_src = ffa_pkg::MS_TAIL;
                    mret_next   = RET_SHRINK;
                    state_next  = S_MRG_RD;
                end
                else
                begin
                    rsp_status_next = ffa_pkg::ST_OK;
                    rsp_res_next    = ffa_pkg::RES_ADDR;
                    state_next      = S_RESP;
                end
            end
            S_MRG_RD, S_MRG_EV:
            begin
                if ((state_reg == S_MRG_RD) && !stat.n_end)
                begin
                    cmd.rd_sel = ffa_pkg::RD_NEXT;
                    state_next = S_MRG_EV;
                end
                else
                begin
                    cmd.wr_sel = (state_reg == S_MRG_EV) ? ffa_pkg::WR_MERGE
                                                         : ffa_pkg::WR_MWORD;
                    case (mret_reg)
                        RET_GROW:
                        begin
                            cmd.h_clear = 1'b1;
                            state_next  = S_G_RD;
                        end
                        RET_SHRINK:
                        begin
                            rsp_status_next = ffa_pkg::ST_OK;
                            rsp_res_next    = ffa_pkg::RES_ADDR;
                            state_next      = S_RESP;
                        end
                        default:
                        begin
                            rsp_status_next = ffa_pkg::ST_OK;
                            rsp_res_next    = ffa_pkg::RES_ZERO;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end
            S_G_RD, S_G_EV:
            begin
                if ((state_reg == S_G_RD) ? stat.h_end : stat.g_over)
                begin
                    // No block fits: a failed grow puts the original header back.
                    if (stat.cmd == ffa_pkg::CMD_RESIZE)
                    begin
                        cmd.wr_sel = ffa_pkg::WR_SAVED;
                    end
                    rsp_status_next = ffa_pkg::ST_NO_MEM;
                    rsp_res_next    = ffa_pkg::RES_ZERO;
                    state_next      = S_RESP;
                end
                else if (state_reg == S_G_RD)
                begin
                    cmd.rd_sel = ffa_pkg::RD_HEAD;
                    state_next = S_G_EV;
                end
                else if (stat.g_fit)
                begin
                    cmd.wr_sel     = ffa_pkg::WR_GRANT;
                    cmd.grant_take = 1'b1;
                    rsp_status_next = ffa_pkg::ST_OK;
                    rsp_res_next    = ffa_pkg::RES_GRANT;
                    if (stat.g_split)
                    begin
                        cmd.mrg_src = ffa_pkg::MS_GRANT;
                        state_next  = S_G_SPLIT;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    cmd.h_advance = 1'b1;
                    state_next    = S_G_RD;
                end
            end
            S_G_SPLIT:
            begin
                cmd.wr_sel = ffa_pkg::WR_MWORD;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                cmd.status  = rsp_status_reg;
                cmd.res_sel = rsp_res_reg;
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mret_reg       <= RET_FREE;
            rsp_status_reg <= ffa_pkg::ST_OK;
            rsp_res_reg    <= ffa_pkg::RES_ZERO;
        end
        else
        begin
            state_reg      <= state_next;
            mret_reg       <= mret_next;
            rsp_status_reg <= rsp_status_next;
            rsp_res_reg    <= rsp_res_next;
        end
    end

endmodule

[rtl/first_fit_heap_allocator.sv]
// First-fit heap allocator over a HEAP_WORDS-word memory kept as an implicit
// list of blocks, each led by a header word (size in words, allocated mark in
// the top bit). One request is handled at a time: allocate, free or resize,
// answered by one item carrying the payload word index and a status. Allocate
// and resize turn a nonzero byte count into words with the divider. The address
// check walks the headers from word 0 to the block being freed or resized, and
// the first-fit search walks from word 0 to the block granted; each visited
// header is read from the header memory before it is evaluated. A finished
// result waits until the previous item has left the output register.
// The header memory has one read with registered data and one write per cycle.
// No clearing pass runs after reset:
// word 0 reads as one free block spanning the heap until it is first written.
// A new request is taken while the previous item still waits in the output
// register.
module first_fit_heap_allocator #(
    parameter int HEAP_WORDS = 4096,
    parameter int WORD_BYTES = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    ffa_req_if.sink   req,
    ffa_rsp_if.source rsp
);
    ffa_pkg::dp_cmd_t  cmd;
    ffa_pkg::dp_stat_t stat;

    // Sequencer: drives the datapath one step per cycle, waiting on the divider and on a busy output register.
    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Datapath: heap memory, walk pointer, merge/split logic, result register.
    ffa_dp #(
        .HEAP_WORDS (HEAP_WORDS),
        .WORD_BYTES (WORD_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_command    (req.command),
        .req_size_bytes (req.size_bytes),
        .req_address    (req.address),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_address    (rsp.result_address),
        .rsp_status     (rsp.status),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

[dv/tb_first_fit_heap_allocator.sv]
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;

    import ffa_pkg::*;

    localparam int HEAP_WORDS = 4096;
    localparam int WORD_BYTES = 4;
    localparam int LIVE_CAP   = 14;
    localparam int RANDOM_ITEMS = 1828;
    // Random allocation mostly stops at LIVE_CAP live blocks, which keeps the
    // header chain short. Even with heavy fragmentation and the receiver
    // stalls, the cap below stays well clear of the slowest correct run.
    localparam int CYCLE_LIMIT = 6000000;
    localparam int DRAIN_CYCLES = 500;

    // One request item together with the answer predicted for it
    typedef struct {
        cmd_t               cmd;
        logic [BYTES_W-1:0] size_bytes;
        logic [ADDR_W-1:0]  address;
        logic [ADDR_W-1:0]  exp_addr;
        status_t            exp_status;
    } heap_req_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } heap_rsp_t;

    logic clk;
    logic rst_n;

    ffa_req_if req_bus();
    ffa_rsp_if rsp_bus();

    first_fit_heap_allocator #(
        .HEAP_WORDS(HEAP_WORDS),
        .WORD_BYTES(WORD_BYTES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_bus),
        .rsp  (rsp_bus)
    );

    // Shadow of the heap memory: header words are all that matter here
    logic [WORD_W-1:0] heap_model [HEAP_WORDS];

    heap_req_t pending_q [$];
    heap_rsp_t answer_q [$];
    int        live_blocks [$];

    heap_req_t cur_req;
    logic      req_taken = 1'b0;
    int        total_items = 0;
    int        accepted_count = 0;
    int        mismatch_count = 0;
    int        run_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Heap predictor
    // ------------------------------------------------------------------

    // Walk the chain from word 0; true when hdr is one of its headers.
    function automatic bit header_on_chain(input longint hdr);
        longint h;
        h = 0;
        while (h < HEAP_WORDS)
        begin
            if (h == hdr)
                return 1'b1;
            h = h + 1 + longint'(heap_model[h][SIZE_BITS-1:0]);
        end
        return 1'b0;
    endfunction

    // Fold a directly following free block into the block at h.
    function automatic void absorb_next(input longint h);
        longint n;
        longint total;
        n = h + 1 + longint'(heap_model[h][SIZE_BITS-1:0]);
        if (n < HEAP_WORDS && !heap_model[n][USED_BIT])
        begin
            total = longint'(heap_model[h][SIZE_BITS-1:0]) + 1 +
                    longint'(heap_model[n][SIZE_BITS-1:0]);
            heap_model[h][SIZE_BITS-1:0] = total[SIZE_BITS-1:0];
        end
    endfunction

    // First-fit search: mark the first free block of at least need words,
    // split off the rest when a header and one payload word fit in it.
    function automatic bit first_fit_take(input longint need, output longint payload);
        longint            h;
        longint            sz;
        longint            blk_end;
        longint            rest;
        logic [WORD_W-1:0] w;
        h = 0;
        payload = 0;
        while (h < HEAP_WORDS)
        begin
            w = heap_model[h];
            sz = longint'(w[SIZE_BITS-1:0]);
            blk_end = h + 1 + sz;
            if (blk_end > HEAP_WORDS)
                return 1'b0;
            if (!w[USED_BIT] && sz >= need)
            begin
                if (sz - need > 1)
                begin
                    rest = sz - need - 1;
                    heap_model[h] = {1'b1, 1'b0, need[SIZE_BITS-1:0]};
                    heap_model[h + 1 + need] = {2'b00, rest[SIZE_BITS-1:0]};
                end
                else
                begin
                    heap_model[h] = {1'b1, 1'b0, sz[SIZE_BITS-1:0]};
                end
                payload = h + 1;
                return 1'b1;
            end
            h = blk_end;
        end
        return 1'b0;
    endfunction

    // Apply one request to the shadow heap and work out its answer.
    function automatic void predict_request(input cmd_t c, input logic [BYTES_W-1:0] nbytes,
                                            input logic [ADDR_W-1:0] addr,
                                            output logic [ADDR_W-1:0] res,
                                            output status_t st);
        longint            need;
        longint            hdr;
        longint            sz;
        longint            rest;
        longint            spot;
        logic [WORD_W-1:0] saved;
        res = '0;
        st = ST_OK;
        spot = 0;
        need = (longint'(nbytes) + WORD_BYTES - 1) / WORD_BYTES;
        hdr = longint'(addr) - 1;
        case (c)
            CMD_ALLOC:
            begin
                if (nbytes == 0)
                    st = ST_ZERO_SIZE;
                else if (first_fit_take(need, spot))
                    res = spot[ADDR_W-1:0];
                else
                    st = ST_NO_MEM;
            end
            CMD_FREE, CMD_RESIZE:
            begin
                // Anything but the payload start of a block in use is refused
                if (addr == 0 || !header_on_chain(hdr) || !heap_model[hdr][USED_BIT])
                begin
                    st = ST_DOUBLE_FREE;
                end
                else if (c == CMD_FREE)
                begin
                    heap_model[hdr][USED_BIT] = 1'b0;
                    absorb_next(hdr);
                end
                else if (nbytes == 0)
                begin
                    st = ST_ZERO_SIZE;
                end
                else
                begin
                    sz = longint'(heap_model[hdr][SIZE_BITS-1:0]);
                    if (sz >= need)
                    begin
                        // Shrink in place; hand the tail back when it can hold a block
                        if (sz - need > 1)
                        begin
                            rest = sz - need - 1;
                            heap_model[hdr] = {1'b1, 1'b0, need[SIZE_BITS-1:0]};
                            heap_model[hdr + 1 + need] = {2'b00, rest[SIZE_BITS-1:0]};
                            absorb_next(hdr + 1 + need);
                        end
                        res = addr;
                    end
                    else
                    begin
                        // Grow: release, then search again; restore on failure
                        saved = heap_model[hdr];
                        heap_model[hdr][USED_BIT] = 1'b0;
                        absorb_next(hdr);
                        if (first_fit_take(need, spot))
                        begin
                            res = spot[ADDR_W-1:0];
                        end
                        else
                        begin
                            heap_model[hdr] = saved;
                            st = ST_NO_MEM;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Predict the request, track which payloads are live, and queue it.
    task automatic queue_request(input cmd_t c, input int nbytes, input int addr);
        heap_req_t         r;
        logic [ADDR_W-1:0] res;
        status_t           st;
        int                idx;
        r.cmd = c;
        r.size_bytes = nbytes[BYTES_W-1:0];
        r.address = addr[ADDR_W-1:0];
        predict_request(r.cmd, r.size_bytes, r.address, res, st);
        r.exp_addr = res;
        r.exp_status = st;
        if (st == ST_OK)
        begin
            idx = -1;
            foreach (live_blocks[i])
                if (live_blocks[i] == int'(r.address))
                    idx = i;
            if (c == CMD_ALLOC)
                live_blocks.push_back(int'(res));
            else if (c == CMD_FREE && idx >= 0)
                live_blocks.delete(idx);
            else if (c == CMD_RESIZE && idx >= 0)
                live_blocks[idx] = int'(res);
        end
        pending_q.push_back(r);
    endtask

    // Mostly small requests, now and then a large one.
    function automatic int pick_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 32);
        else if (r < 92)
            return $urandom_range(33, 256);
        else if (r < 98)
            return $urandom_range(257, 2048);
        else
            return $urandom_range(2049, 16384);
    endfunction

    initial
    begin
        int pick;
        int kind;
        int victim;
        int random_count;

        // Hold everything at known values through reset
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.command = CMD_ALLOC;
        req_bus.size_bytes = '0;
        req_bus.address = '0;
        rsp_bus.ready = 1'b0;

        // Heap after reset: one free block spanning everything past word 0
        foreach (heap_model[i])
            heap_model[i] = '0;
        heap_model[0] = {2'b00, 30'(HEAP_WORDS - 1)};

        // Directed part: extremes and the corner cases of each command
        queue_request(CMD_ALLOC, 0, 0);          // zero size
        queue_request(CMD_ALLOC, 16384, 0);      // larger than the heap
        queue_request(CMD_ALLOC, 16380, 0);      // whole heap in one block
        queue_request(CMD_ALLOC, 1, 0);          // heap full
        queue_request(CMD_RESIZE, 16384, 1);     // failed grow, block kept
        queue_request(CMD_FREE, 0, 1);
        queue_request(CMD_FREE, 0, 1);           // double free
        queue_request(CMD_FREE, 0, 0);           // address zero
        queue_request(CMD_ALLOC, 1, 0);          // one word, split
        queue_request(CMD_ALLOC, 5, 0);          // rounds up to two words
        queue_request(CMD_FREE, 0, 4);           // word inside a block
        queue_request(CMD_FREE, 0, 4095);        // top address, not a block
        queue_request(CMD_ALLOC, 16356, 0);      // one word left over, no split
        queue_request(CMD_RESIZE, 0, 3);         // resize to zero size
        queue_request(CMD_RESIZE, 4, 3);         // shrink by one word, no split
        queue_request(CMD_FREE, 0, 6);
        queue_request(CMD_RESIZE, 40, 1);        // grow by moving the block
        queue_request(CMD_RESIZE, 4, 6);         // shrink with tail split and merge
        queue_request(CMD_RESIZE, 8, 1);         // resize of a free block
        queue_request(CMD_NONE, 16384, 4095);    // unused command
        queue_request(CMD_ALLOC, 16352, 0);      // exact fit of the big free block
        queue_request(CMD_RESIZE, 16384, 3);     // failed grow with the next block in use
        queue_request(CMD_FREE, 0, 8);

        // Random part: mostly well-formed alloc/free/resize on live blocks
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                kind = $urandom_range(0, 5);
                case (kind)
                    0: queue_request(cmd_t'($urandom_range(1, 2)), pick_bytes(),
                                     $urandom_range(0, 4095));
                    1:
                    begin
                        if (live_blocks.size() != 0)
                            victim = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                        else
                            victim = 1;
                        queue_request(cmd_t'($urandom_range(1, 2)), pick_bytes(),
                                      victim + $urandom_range(1, 3));
                    end
                    2:
                    begin
                        if (live_blocks.size() != 0)
                            victim = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                        else
                            victim = 1;
                        queue_request(CMD_FREE, 0, victim);
                        queue_request(cmd_t'($urandom_range(1, 2)), pick_bytes(), victim);
                        random_count++;
                    end
                    3:
                    begin
                        if (live_blocks.size() != 0)
                            victim = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                        else
                            victim = 0;
                        queue_request(($urandom_range(0, 1) != 0) ? CMD_RESIZE : CMD_ALLOC,
                                      0, victim);
                    end
                    4: queue_request(CMD_NONE, $urandom_range(0, 16384),
                                     $urandom_range(0, 4095));
                    default: queue_request(CMD_ALLOC, ($urandom_range(0, 1) != 0) ? 16384 :
                                           $urandom_range(0, 16384), $urandom_range(0, 4095));
                endcase
                // the unused command changes nothing, so it does not count
                if (kind != 4)
                    random_count++;
            end
            else if (live_blocks.size() == 0 || (pick < 50 && live_blocks.size() < LIVE_CAP))
            begin
                queue_request(CMD_ALLOC, pick_bytes(), $urandom_range(0, 4095));
                random_count++;
            end
            else if (pick < 84)
            begin
                victim = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                queue_request(CMD_FREE, $urandom_range(0, 16384), victim);
                random_count++;
            end
            else
            begin
                victim = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                queue_request(CMD_RESIZE, pick_bytes(), victim);
                random_count++;
            end
        end
        total_items = pending_q.size();

        // Release reset away from the rising edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every item is in and every answer is back
        while ((accepted_count != total_items || answer_q.size() != 0) &&
               run_cycles < CYCLE_LIMIT)
            @(negedge clk);

        if (run_cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
        end
        else
        begin
            // Give a stray extra answer time to show up
            repeat (DRAIN_CYCLES) @(negedge clk);
            if (mismatch_count == 0 && answer_q.size() == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            // Idle mix per third of the run: slow receiver, slow sender, none
            if (accepted_count < total_items / 3)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 79;
            end
            else if (accepted_count < (2 * total_items) / 3)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Hold the item until it is taken, then advance or idle
            if (!req_bus.valid || req_taken)
            begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_req = pending_q.pop_front();
                    req_bus.valid <= 1'b1;
                    req_bus.command <= cur_req.cmd;
                    req_bus.size_bytes <= cur_req.size_bytes;
                    req_bus.address <= cur_req.address;
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end

            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample handshakes on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        heap_rsp_t want;
        run_cycles <= run_cycles + 1;
        req_taken <= rst_n && req_bus.valid && req_bus.ready;
        if (rst_n)
        begin
            // Accepted request: its answer is now owed
            if (req_bus.valid && req_bus.ready)
            begin
                want.addr = cur_req.exp_addr;
                want.status = cur_req.exp_status;
                answer_q.push_back(want);
                accepted_count <= accepted_count + 1;
            end

            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (answer_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected answer item: addr %0d status %0d",
                                 rsp_bus.result_address, rsp_bus.status);
                    mismatch_count++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp_bus.result_address !== want.addr || rsp_bus.status !== want.status)
                    begin
                        if (mismatch_count < 10)
                            $display("answer mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                                     want.addr, want.status,
                                     rsp_bus.result_address, rsp_bus.status);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule
